FILE: hdl/stbs_pkg.sv
// Shared constants for the sorted table binary search unit.
package stbs_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned ENTRY_WIDTH_DEF = 32;
    localparam int unsigned COUNT_REG_W     = 11;
    localparam int unsigned APB_ADDR_W      = 3;
    localparam int unsigned APB_DATA_W      = 32;

    localparam logic REG_ENTRY_COUNT    = 1'b0;
    localparam logic REG_COMPARE_SIGNED = 1'b1;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

endpackage

FILE: hdl/stbs_probe.sv
// One binary search probe: registered table copy read, then registered compare and narrow.
module stbs_probe #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned EW    = 32,
    parameter int unsigned IW    = 10,
    parameter int unsigned CW    = 11,
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_signed,
    input  t_item i_item,
    output t_item o_item
);
    import stbs_pkg::*;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_q;
    t_item         r_a;
    t_item         r_b;
    t_item         n_b;

    logic [CW:0]   in_sum;
    logic [IW-1:0] in_mid;
    logic [CW:0]   a_sum;
    logic [IW-1:0] a_mid;
    logic [EW-1:0] flip;
    logic [EW-1:0] cmp_a;
    logic [EW-1:0] cmp_b;
    logic          active;

    // The midpoint is floor((low + high) / 2) where high is one less than the hi bound.
    always_comb begin
        in_sum = {1'b0, i_item.lo} + {1'b0, i_item.hi} - (CW + 1)'(1);
        in_mid = in_sum[IW:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (i_en) begin
            r_a <= i_item;
        end
    end

    // Each write item passes every probe and updates that probe's copy in order.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_item.valid && i_item.search == ACT_WRITE
                && {1'b0, i_item.idx} < (IW + 1)'(DEPTH)) begin
                r_mem[i_item.idx] <= i_item.value;
            end
            r_q <= r_mem[in_mid];
        end
    end

    always_comb begin
        a_sum  = {1'b0, r_a.lo} + {1'b0, r_a.hi} - (CW + 1)'(1);
        a_mid  = a_sum[IW:1];
        flip   = {i_signed, {(EW - 1){1'b0}}};
        cmp_a  = r_q ^ flip;
        cmp_b  = r_a.key ^ flip;
        active = r_a.valid && r_a.search == ACT_SEARCH && !r_a.hit && r_a.lo < r_a.hi;
        n_b    = r_a;
        if (active) begin
            if (cmp_a == cmp_b) begin
                n_b.hit = 1'b1;
                n_b.pos = a_mid;
            end else if (cmp_a > cmp_b) begin
                n_b.hi = CW'(a_mid);
            end else begin
                n_b.lo = CW'(a_mid) + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (i_en) begin
            r_b <= n_b;
        end
    end

    assign o_item = r_b;

endmodule

FILE: hdl/sorted_table_binary_search_unit.sv
// A search passes the input register, each probe stage and the output register in order.
// Throughput: one item per cycle unless stalled; each probe owns a table copy and a read port.
// Write items travel the same pipeline and update each copy in turn, so order is kept.
// The whole pipeline halts while a result waits at the output register.
// Reset (synchronous, active low) clears valid bits, entry_count to 0, compare_signed to 1.
// Table contents are not cleared by reset and are undefined until written.
module sorted_table_binary_search_unit #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned ENTRY_WIDTH = stbs_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic                                      i_action,
    input  logic [$clog2(TABLE_DEPTH)-1:0]            i_entry_index,
    input  logic [ENTRY_WIDTH-1:0]                    i_entry_value,
    input  logic [ENTRY_WIDTH-1:0]                    i_search_key,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic                                      o_found,
    output logic [$clog2(TABLE_DEPTH)-1:0]            o_position,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [stbs_pkg::APB_ADDR_W-1:0]           paddr,
    input  logic [stbs_pkg::APB_DATA_W-1:0]           pwdata,
    output logic [stbs_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);
    import stbs_pkg::*;

    localparam int unsigned IW     = $clog2(TABLE_DEPTH);
    localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned NPROBE = CW;
    localparam int unsigned CNTW   = (CW > COUNT_REG_W) ? CW : COUNT_REG_W;

    typedef struct packed {
        logic                   valid;
        logic                   search;
        logic [IW-1:0]          idx;
        logic [ENTRY_WIDTH-1:0] value;
        logic [ENTRY_WIDTH-1:0] key;
        logic [CW-1:0]          lo;
        logic [CW-1:0]          hi;
        logic                   hit;
        logic [IW-1:0]          pos;
    } t_item;

    logic [CNTW-1:0] r_entry_count;
    logic            r_compare_signed;
    logic [CW-1:0]   count_eff;
    logic            en;
    t_item           r_in;
    t_item           items [NPROBE + 1];
    logic            r_o_valid;
    logic            r_found;
    logic [IW-1:0]   r_position;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count    <= '0;
            r_compare_signed <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_ENTRY_COUNT:    r_entry_count    <= CNTW'(pwdata[COUNT_REG_W-1:0]);
                REG_COMPARE_SIGNED: r_compare_signed <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ENTRY_COUNT:    prdata = APB_DATA_W'(r_entry_count);
            REG_COMPARE_SIGNED: prdata = APB_DATA_W'(r_compare_signed);
            default:            prdata = '0;
        endcase
    end

    // Counts above the table depth search the whole table.
    assign count_eff = (r_entry_count > CNTW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                           : CW'(r_entry_count);

    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (en) begin
            r_in.valid  <= i_valid;
            r_in.search <= i_action;
            r_in.idx    <= i_entry_index;
            r_in.value  <= i_entry_value;
            r_in.key    <= i_search_key;
            r_in.lo     <= '0;
            r_in.hi     <= count_eff;
            r_in.hit    <= 1'b0;
            r_in.pos    <= '0;
        end
    end

    assign items[0] = r_in;

    for (genvar k = 0; k < NPROBE; k++) begin : g_probe
        stbs_probe #(
            .DEPTH  (TABLE_DEPTH),
            .EW     (ENTRY_WIDTH),
            .IW     (IW),
            .CW     (CW),
            .t_item (t_item)
        ) u_probe (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_signed (r_compare_signed),
            .i_item   (items[k]),
            .o_item   (items[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid  <= items[NPROBE].valid && items[NPROBE].search == ACT_SEARCH;
            r_found    <= items[NPROBE].hit;
            r_position <= items[NPROBE].pos;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_found    = r_found;
    assign o_position = r_position;

endmodule

FILE: hdl/stbs_checker.sv
// Port-level checks for the sorted table binary search unit, bound to the top level.
module stbs_checker #(
    parameter int unsigned PW = 10
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_ready,
    input logic          o_ready,
    input logic          o_found,
    input logic [PW-1:0] o_position,
    input logic          pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_position))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_position == '0)
        else $error("miss carries a nonzero position");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready && pready)
        else $error("input stalled with empty output register");

endmodule

bind sorted_table_binary_search_unit stbs_checker #(.PW(IW)) u_stbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_ready    (o_ready),
    .o_found    (o_found),
    .o_position (o_position),
    .pready     (pready)
);
